@@ rtl/rle_row_byte_decoder_defines.svh @@
// Assertion macros shared by the decoder modules.
`ifndef RLE_ROW_BYTE_DECODER_DEFINES_SVH
`define RLE_ROW_BYTE_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RRBD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrbd check failed");

// Next-cycle implication, checked out of reset.
`define RRBD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrbd check failed");

`endif

@@ rtl/rrbd_pkg.sv @@
package rrbd_pkg;

	// Output packing
	localparam int OUT_LANES = 8;
	localparam int MAX_RES   = 16;
	localparam int RUN_CAP   = OUT_LANES * MAX_RES;

	// Command queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b1;

	// Row parser phase
	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_LITERAL = 4'b0010,
		PH_RUN     = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	// One classified request: total bytes of value to emit, 0 for a marker or a dropped byte
	typedef struct packed {
		logic [7:0] value;
		logic [6:0] total;
		logic       row_end;
		logic       overflow;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

endpackage

@@ rtl/rrbd_in_if.sv @@
interface rrbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_row;

	modport source (output valid, output data_byte, output first_of_row, input ready);
	modport sink   (input valid, input data_byte, input first_of_row, output ready);
endinterface

@@ rtl/rrbd_out_if.sv @@
interface rrbd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        last_of_item;
	logic        row_end;
	logic        overflow;

	modport source (output valid, output out_bytes, output byte_count, output last_of_item,
		output row_end, output overflow, input ready);
	modport sink   (input valid, input out_bytes, input byte_count, input last_of_item,
		input row_end, input overflow, output ready);
endinterface

@@ rtl/rle_row_byte_decoder.sv @@
// Run-length row decoder for one image channel row, one coded byte per request on "coded",
// decoded bytes packed up to eight per request on "decoded" (lane zero earliest). The front
// end parses headers and takes a new byte every cycle while its four-entry command queue has
// room; header bytes other than an end marker leave no command. The back end loads a
// command and emits one result per cycle while the receiver keeps up (one per eight bytes of
// a run) and loads no new one before its last result; back-end throughput sets the sustained
// rate and the queue absorbs short bursts. The result register holds a finished result while
// the next is formed. There is no start-up sweep: the block is ready straight out of reset.
// Write rle_mode and row_width only while no results are outstanding.
module rle_row_byte_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rrbd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                   cfg_data,
	rrbd_in_if.sink                       coded,
	rrbd_out_if.source                    decoded
);
	import rrbd_pkg::*;

	push_t push;
	logic  full;
	cmd_t  head;
	logic  empty;
	logic  pop;

	rrbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.coded    (coded),
		.push     (push),
		.full     (full)
	);

	rrbd_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	rrbd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.decoded (decoded)
	);

endmodule

@@ rtl/rrbd_cmd_fifo.sv @@
`include "rle_row_byte_decoder_defines.svh"

module rrbd_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  rrbd_pkg::push_t push,
	output logic           full,
	input  logic           pop,
	output rrbd_pkg::cmd_t head,
	output logic           empty
);
	import rrbd_pkg::*;

	cmd_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`RRBD_ASSERT_IMP(a_fill_bound, 1'b1, cnt_q <= CNT_W'(FIFO_DEPTH))
	`RRBD_ASSERT_NXT(a_fill_up, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)
	`RRBD_ASSERT_NXT(a_fill_down, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1)

endmodule

@@ rtl/rrbd_front.sv @@
module rrbd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rrbd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                   cfg_data,
	rrbd_in_if.sink                       coded,
	output rrbd_pkg::push_t               push,
	input  logic                          full
);
	import rrbd_pkg::*;

	logic        rle_mode_q;
	logic [15:0] row_width_q;
	phase_t      ph_q, ph_e, ph_n;
	logic [6:0]  rem_q, rem_e, rem_n;
	logic [15:0] col_q, col_e, col_n;
	logic        ovf_q, ovf_e, ovf_n;
	logic        accept;
	logic        fits;
	logic [15:0] col_inc;
	logic [15:0] room;
	logic [6:0]  take;
	logic        emit;
	cmd_t        cmd;

	assign coded.ready = !full;
	assign accept      = coded.valid && !full;

	// state as seen after a row restart
	always_comb begin
		if (coded.first_of_row) begin
			ph_e  = PH_HEADER;
			rem_e = '0;
			col_e = '0;
			ovf_e = 1'b0;
		end else begin
			ph_e  = ph_q;
			rem_e = rem_q;
			col_e = col_q;
			ovf_e = ovf_q;
		end
	end

	assign fits    = (col_e < row_width_q);
	assign col_inc = col_e + 16'd1;
	assign room    = fits ? (row_width_q - col_e) : 16'd0;

	// run length clipped to the row and to the result limit
	always_comb begin
		if ({9'd0, rem_e} < room) begin
			take = rem_e;
		end else begin
			take = room[6:0];
		end
		if (32'(take) > RUN_CAP) begin
			take = 7'(RUN_CAP);
		end
	end

	// classify the byte and work out the next parser state
	always_comb begin
		ph_n         = ph_e;
		rem_n        = rem_e;
		col_n        = col_e;
		ovf_n        = ovf_e;
		emit         = 1'b0;
		cmd.value    = coded.data_byte;
		cmd.total    = '0;
		cmd.row_end  = 1'b0;
		if (!rle_mode_q) begin
			emit = 1'b1;
			if (ph_e == PH_DONE) begin
				ovf_n = 1'b1;
			end else if (fits) begin
				col_n     = col_inc;
				cmd.total = 7'd1;
				if (col_inc >= row_width_q) begin
					ph_n        = PH_DONE;
					cmd.row_end = 1'b1;
				end
			end else begin
				ovf_n = 1'b1;
			end
		end else begin
			unique case (ph_e)
				PH_HEADER: begin
					if (coded.data_byte[6:0] == 7'd0) begin
						ph_n        = PH_DONE;
						emit        = 1'b1;
						cmd.row_end = 1'b1;
					end else begin
						rem_n = coded.data_byte[6:0];
						ph_n  = coded.data_byte[7] ? PH_LITERAL : PH_RUN;
					end
				end
				PH_LITERAL: begin
					emit = 1'b1;
					if (fits) begin
						col_n     = col_inc;
						cmd.total = 7'd1;
					end else begin
						ovf_n = 1'b1;
					end
					rem_n = rem_e - 7'd1;
					if (rem_e == 7'd1) begin
						ph_n = PH_HEADER;
					end
				end
				PH_RUN: begin
					emit      = 1'b1;
					cmd.total = take;
					col_n     = col_e + {9'd0, take};
					if (take < rem_e) begin
						ovf_n = 1'b1;
					end
					rem_n = '0;
					ph_n  = PH_HEADER;
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
		cmd.overflow = ovf_n;
	end

	assign push.valid = accept && emit;
	assign push.cmd   = cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_mode_q  <= 1'b1;
			row_width_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RLE_MODE:  rle_mode_q  <= cfg_data[0];
				CFG_ROW_WIDTH: row_width_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HEADER;
			rem_q <= '0;
			col_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			ph_q  <= ph_n;
			rem_q <= rem_n;
			col_q <= col_n;
			ovf_q <= ovf_n;
		end
	end

endmodule

@@ rtl/rrbd_back.sv @@
`include "rle_row_byte_decoder_defines.svh"

module rrbd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rrbd_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	rrbd_out_if.source     decoded
);
	import rrbd_pkg::*;

	logic        busy_q;
	logic [7:0]  val_q;
	logic [6:0]  rem_q;
	logic        rend_q;
	logic        ovf_q;
	logic        ov_valid_q;
	logic [63:0] ov_bytes_q;
	logic [3:0]  ov_count_q;
	logic        ov_last_q;
	logic        ov_rend_q;
	logic        ov_ovf_q;
	logic        step;
	logic [3:0]  lanes;
	logic [6:0]  rem_next;
	logic        last;
	logic [63:0] word;

	assign pop  = !busy_q && !empty;
	assign step = busy_q && (!ov_valid_q || decoded.ready);

	// lanes for the next result and the replicated word
	always_comb begin
		if (rem_q >= 7'(OUT_LANES)) begin
			lanes = 4'(OUT_LANES);
		end else begin
			lanes = rem_q[3:0];
		end
		rem_next = rem_q - {3'd0, lanes};
		last     = (rem_next == 7'd0);
		word     = '0;
		for (int i = 0; i < OUT_LANES; i++) begin
			if (4'(i) < lanes) begin
				word[8*i +: 8] = val_q;
			end
		end
	end

	// working command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
		end else if (step && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			val_q  <= head.value;
			rem_q  <= head.total;
			rend_q <= head.row_end;
			ovf_q  <= head.overflow;
		end else if (step) begin
			rem_q <= rem_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_valid_q <= 1'b0;
		end else if (step) begin
			ov_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			ov_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ov_bytes_q <= word;
			ov_count_q <= lanes;
			ov_last_q  <= last;
			ov_rend_q  <= rend_q && last;
			ov_ovf_q   <= ovf_q;
		end
	end

	assign decoded.valid        = ov_valid_q;
	assign decoded.out_bytes    = ov_bytes_q;
	assign decoded.byte_count   = ov_count_q;
	assign decoded.last_of_item = ov_last_q;
	assign decoded.row_end      = ov_rend_q;
	assign decoded.overflow     = ov_ovf_q;

	`RRBD_ASSERT_IMP(a_lane_bound, ov_valid_q, ov_count_q <= 4'(OUT_LANES))
	`RRBD_ASSERT_IMP(a_marker_last, ov_valid_q && ov_count_q == 4'd0, ov_last_q)
	`RRBD_ASSERT_IMP(a_rowend_last, ov_valid_q && ov_rend_q, ov_last_q)
	`RRBD_ASSERT_NXT(a_stay_busy, step && !last, busy_q)

endmodule

@@ sim/decode_checker.sv @@
module decode_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rrbd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                    cfg_data,
	rrbd_in_if                             coded,
	rrbd_out_if                            decoded,
	output int                             failures,
	output int                             backlog,
	output int                             words_checked
);
	import rrbd_pkg::*;

	// One decoded word as it should appear on the output channel
	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        last;
		logic        row_end;
		logic        ovf;
	} word_t;

	word_t       word_q[$];

	// Shadow of the registers and of the row parser
	logic        rle_on;
	logic [15:0] width;
	phase_t      phase;
	logic [6:0]  left;
	logic [15:0] col;
	logic        ovf_seen;

	task automatic report(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		failures++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report($sformatf("word %0d %s: got %h, expected %h",
				words_checked, name, got, want));
	endtask

	// Keep one byte if the row has room, otherwise drop it and flag overflow
	function automatic word_t place_single(input logic [7:0] b);
		word_t w;
		w = '0;
		if (col < width) begin
			col = col + 16'd1;
			w.bytes[7:0] = b;
			w.count = 4'd1;
		end else begin
			ovf_seen = 1'b1;
		end
		return w;
	endfunction

	// Work out the words caused by one accepted coded byte
	function automatic void decode_byte(input logic [7:0] b, input logic first);
		word_t       res[$];
		word_t       w;
		int unsigned want, room, take, lanes;
		if (first) begin
			phase = PH_HEADER;
			left = '0;
			col = '0;
			ovf_seen = 1'b0;
		end
		if (!rle_on) begin
			// raw pass-through; any phase but done counts as an open row
			if (phase == PH_DONE) begin
				ovf_seen = 1'b1;
				res.push_back('0);
			end else begin
				w = place_single(b);
				if (col >= width && w.count != 0) begin
					phase = PH_DONE;
					w.row_end = 1'b1;
				end
				res.push_back(w);
			end
		end else begin
			case (phase)
				PH_HEADER: begin
					if (b[6:0] == 7'd0) begin
						phase = PH_DONE;
						w = '0;
						w.row_end = 1'b1;
						res.push_back(w);
					end else begin
						left = b[6:0];
						phase = b[7] ? PH_LITERAL : PH_RUN;
					end
				end
				PH_LITERAL: begin
					res.push_back(place_single(b));
					left = left - 7'd1;
					if (left == 7'd0)
						phase = PH_HEADER;
				end
				PH_RUN: begin
					// clip the run to the room left in the row and the word limit
					want = left;
					room = (col < width) ? width - col : 0;
					take = (want < room) ? want : room;
					if (take > RUN_CAP)
						take = RUN_CAP;
					if (take < want)
						ovf_seen = 1'b1;
					col = col + 16'(take);
					while (take > 0) begin
						lanes = (take < OUT_LANES) ? take : OUT_LANES;
						w = '0;
						for (int i = 0; i < lanes; i++)
							w.bytes[8*i +: 8] = b;
						w.count = 4'(lanes);
						res.push_back(w);
						take -= lanes;
					end
					if (res.size() == 0)
						res.push_back('0);
					left = '0;
					phase = PH_HEADER;
				end
				default: ;
			endcase
		end
		foreach (res[k]) begin
			res[k].ovf = ovf_seen;
			res[k].last = (k == res.size() - 1);
			word_q.push_back(res[k]);
		end
	endfunction

	// Follow register writes, coded requests and decoded requests
	always @(posedge clk or negedge arst_n) begin
		word_t exp_w;
		if (!arst_n) begin
			rle_on = 1'b1;
			width = 16'hFFFF;
			phase = PH_HEADER;
			left = '0;
			col = '0;
			ovf_seen = 1'b0;
			word_q.delete();
			failures = 0;
			backlog = 0;
			words_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RLE_MODE:  rle_on = cfg_data[0];
					CFG_ROW_WIDTH: width = cfg_data;
					default: ;
				endcase
			end
			if (coded.valid && coded.ready)
				decode_byte(coded.data_byte, coded.first_of_row);
			if (decoded.valid && decoded.ready) begin
				if (word_q.size() == 0) begin
					report($sformatf("word %0d arrived with nothing expected", words_checked));
				end else begin
					exp_w = word_q.pop_front();
					check_field("out_bytes", decoded.out_bytes, exp_w.bytes);
					check_field("byte_count", 64'(decoded.byte_count), 64'(exp_w.count));
					check_field("last_of_item", 64'(decoded.last_of_item), 64'(exp_w.last));
					check_field("row_end", 64'(decoded.row_end), 64'(exp_w.row_end));
					check_field("overflow", 64'(decoded.overflow), 64'(exp_w.ovf));
				end
				words_checked++;
			end
			backlog = word_q.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
module testbench;
	import rrbd_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [15:0]          cfg_data;

	int          gap_pct = 0;
	int          stall_pct = 0;
	int          items_sent = 0;
	int          settings_n = 0;
	int          seg_end;
	logic        rle_now;
	logic [15:0] width_now;

	int          failures;
	int          backlog;
	int          words_checked;

	rrbd_in_if  coded_if();
	rrbd_out_if decoded_if();

	rle_row_byte_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.coded    (coded_if),
		.decoded  (decoded_if)
	);

	decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.coded         (coded_if),
		.decoded       (decoded_if),
		.failures      (failures),
		.backlog       (backlog),
		.words_checked (words_checked)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure
	always @(posedge clk) begin
		decoded_if.ready <= ($urandom_range(99, 0) >= stall_pct);
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// One coded request, after a random number of idle cycles
	task automatic send_byte(input logic [7:0] b, input logic first);
		if ($urandom_range(99, 0) < gap_pct) begin
			coded_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99, 0) < gap_pct)
				@(posedge clk);
		end
		coded_if.valid <= 1'b1;
		coded_if.data_byte <= b;
		coded_if.first_of_row <= first;
		@(posedge clk);
		while (!coded_if.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stop sending and wait for every outstanding word, plus settling time
	task automatic drain;
		coded_if.valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// Write both registers; only called once drained
	task automatic set_config(input logic mode, input logic [15:0] w);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_RLE_MODE;
		cfg_data <= {15'd0, mode};
		@(posedge clk);
		cfg_idx <= CFG_ROW_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		rle_now = mode;
		width_now = w;
		settings_n++;
	endtask

	task automatic set_idling(input int sel);
		case (sel % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 61; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 61; end
			default: begin gap_pct = 27; stall_pct = 27; end
		endcase
	endtask

	// Mostly well-formed run-length rows, with some broken ends and noise
	task automatic send_coded_row;
		int   n_pkt, cnt, p, k, r;
		logic lead;
		lead = ($urandom_range(19, 0) != 0);
		n_pkt = $urandom_range(4, 1);
		for (p = 0; p < n_pkt; p++) begin
			r = $urandom_range(99, 0);
			if (r < 80)
				cnt = $urandom_range(6, 1);
			else if (r < 97)
				cnt = $urandom_range(40, 7);
			else
				cnt = $urandom_range(127, 80);
			if ($urandom_range(1, 0) == 1) begin
				// literal packet; long ones mostly trimmed to spare the byte budget
				if (cnt > 12 && $urandom_range(9, 0) != 0)
					cnt = $urandom_range(12, 1);
				send_byte({1'b1, 7'(cnt)}, lead);
				lead = 1'b0;
				for (k = 0; k < cnt; k++)
					send_byte(8'($urandom_range(255, 0)), 1'b0);
			end else begin
				send_byte({1'b0, 7'(cnt)}, lead);
				lead = 1'b0;
				send_byte(8'($urandom_range(255, 0)), 1'b0);
			end
		end
		r = $urandom_range(99, 0);
		if (r < 80) begin
			send_byte({1'($urandom_range(1, 0)), 7'd0}, 1'b0);
			if ($urandom_range(6, 0) == 0)
				send_byte(8'($urandom_range(255, 0)), 1'b0);
		end else if (r < 90) begin
			// literal cut short by the next row start
			send_byte(8'h85, 1'b0);
			send_byte(8'($urandom_range(255, 0)), 1'b0);
		end else begin
			send_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
		end
	endtask

	// Raw rows: up to width 24 mostly exactly one row wide, sometimes short or running past; wider rows short
	task automatic send_raw_row;
		int len, k;
		if (width_now > 24)
			len = $urandom_range(12, 1);
		else if ($urandom_range(9, 0) < 7)
			len = width_now;
		else
			len = $urandom_range(width_now + 3, 1);
		for (k = 0; k < len; k++)
			send_byte(8'($urandom_range(255, 0)),
				(k == 0) && ($urandom_range(19, 0) != 0));
	endtask

	initial begin
		int seg;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		coded_if.valid = 1'b0;
		coded_if.data_byte = '0;
		coded_if.first_of_row = 1'b0;
		decoded_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: literal and run packets, full-length run, end markers
		set_idling(3);
		set_config(1'b1, 16'hFFFF);
		send_byte(8'h83, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		// byte after the row end is ignored
		send_byte(8'h11, 1'b0);
		// row that ends at once
		send_byte(8'h00, 1'b1);

		// Directed: literal and run past a narrow row
		drain;
		set_config(1'b1, 16'd2);
		send_byte(8'h83, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h04, 1'b0);
		send_byte(8'h0A, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h00, 1'b0);

		// Directed: raw row end and a byte beyond it
		drain;
		set_config(1'b0, 16'd3);
		send_byte(8'hF0, 1'b1);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);

		// Directed: mode switched in the middle of a literal packet
		drain;
		set_config(1'b1, 16'hFFFF);
		send_byte(8'h82, 1'b1);
		send_byte(8'h11, 1'b0);
		drain;
		set_config(1'b0, 16'hFFFF);
		send_byte(8'h22, 1'b0);
		drain;
		set_config(1'b1, 16'hFFFF);
		send_byte(8'h33, 1'b0);
		send_byte(8'h80, 1'b0);

		// Random segments, each with its own setting and idling pattern
		for (seg = 0; seg < 8; seg++) begin
			drain;
			case (seg)
				0: set_config(1'b1, 16'hFFFF);
				1: set_config(1'b1, 16'd1);
				2: set_config(1'b0, 16'd1);
				3: set_config(1'b0, 16'($urandom_range(20, 2)));
				4: set_config(1'b1, 16'($urandom_range(200, 8)));
				5: set_config(1'b0, 16'hFFFF);
				6: set_config(1'b1, 16'($urandom_range(64, 1)));
				default: set_config(1'b1, 16'hFFFF);
			endcase
			set_idling(seg);
			seg_end = items_sent + 46;
			while (items_sent < seg_end) begin
				// occasionally hold off until the output side is empty
				if ($urandom_range(39, 0) == 0)
					drain;
				if (rle_now)
					send_coded_row();
				else
					send_raw_row();
			end
		end
		drain;

		$display("Sent %0d coded bytes, checked %0d decoded words over %0d register settings",
			items_sent, words_checked, settings_n);
		$display("Rows: literal/run packets, end markers, overflow drops, raw rows, mode switches");
		if (failures == 0 && backlog == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rrbd_pkg.sv
rtl/rrbd_in_if.sv
rtl/rrbd_out_if.sv
rtl/rrbd_cmd_fifo.sv
rtl/rrbd_front.sv
rtl/rrbd_back.sv
rtl/rle_row_byte_decoder.sv
sim/decode_checker.sv
sim/testbench.sv
